>>> design/first_fit_heap_allocator_core_defines.svh
// assertion macros shared by the heap allocator rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH

// condition holds at every edge out of reset
`define FFHA_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// consequent holds in the same cycle as the antecedent
`define FFHA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define FFHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/ffha_pkg.sv
// types, codes and fixed widths of the first-fit heap allocator
// no dependencies; used by the allocator core, ffha_alu and the testbench
package ffha_pkg;

  // heap geometry fixed by the 10-bit address fields
  localparam int ADDR_W     = 10;
  localparam int SIZE_W     = 11;
  localparam int ALU_W      = 12;
  localparam int HEAP_BYTES = 1024;

  // reset value of the split threshold register
  localparam logic [ADDR_W-1:0] MSR_RESET = 10'd24;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [ALU_W-1:0]  alu_word_t;

  // operation codes
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // one free segment table entry
  typedef struct packed {
    addr_t start;
    size_t length;
  } seg_t;

  // shared add / subtract / compare unit
  typedef struct packed {
    alu_word_t a;
    alu_word_t b;
  } alu_req_t;

  typedef struct packed {
    alu_word_t sum;
    alu_word_t diff;
    logic      ge;
    logic      gt;
    logic      eq;
  } alu_res_t;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_A_NEED,
    S_A_SCAN,
    S_A_THR,
    S_A_CMP,
    S_A_SPLIT,
    S_A_BLK,
    S_A_TAKE,
    S_A_USER,
    S_F_RANGE,
    S_F_LIM,
    S_F_CLIP,
    S_F_SCAN,
    S_F_PEND,
    S_F_JP,
    S_F_END,
    S_F_JN,
    S_F_MERGE1,
    S_F_MERGE2,
    S_F_PREV,
    S_F_NEXT,
    S_F_SHUP,
    S_F_INS,
    S_DROP,
    S_DONE
  } state_t;

endpackage

>>> design/first_fit_heap_allocator_core.sv
// first-fit heap allocator with an address-sorted, coalescing free segment table
// depends on ffha_pkg, ffha_alu, ffha_ram and first_fit_heap_allocator_core_defines.svh
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+------------------------------------------
//   in_      | input     | in_valid / in_stall   | kind, request_size, free_address
//   out_     | output    | out_valid / out_stall | status, user_address
//   cfg_     | input     | cfg_valid / cfg_ready | min_split_remainder
//
// one transaction at a time; in_stall stays high until the sequencer is back in S_IDLE.
// an allocate scans for the first segment that fits, then splits it or takes it whole; a free
// scans, then merges or opens a hole; scan and shift move one table entry per cycle through
// the segment ram read port, and the result goes to the output register.
// after reset the S_INIT state writes the initial whole-heap segment before in_stall drops.
// a result waits in the output register under out_stall while the next transaction runs.
`include "first_fit_heap_allocator_core_defines.svh"

module first_fit_heap_allocator_core #(
  parameter int MAX_SEGMENTS = 128,
  parameter int HEADER_BYTES = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  // input transactions
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_kind,
  input  ffha_pkg::addr_t     in_request_size,
  input  ffha_pkg::addr_t     in_free_address,
  // results
  output logic                out_valid,
  input  logic                out_stall,
  output ffha_pkg::status_t   out_status,
  output ffha_pkg::addr_t     out_user_address,
  // configuration write
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  ffha_pkg::addr_t     cfg_min_split_remainder
);
  import ffha_pkg::*;

  localparam int IW    = $clog2(MAX_SEGMENTS);
  localparam int CW    = $clog2(MAX_SEGMENTS + 1);
  localparam int SEG_W = $bits(seg_t);

  localparam alu_word_t HDR_W  = ALU_W'(HEADER_BYTES);
  localparam alu_word_t HEAP_W = ALU_W'(HEAP_BYTES);

  // control registers
  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;
  addr_t         msr_r;

  // working registers
  logic          kind_r, kind_nxt;
  addr_t         opnd_r, opnd_nxt;
  size_t         need_r, need_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] src_r, src_nxt;
  logic          pend_r, pend_nxt;
  logic [CW-1:0] hit_r, hit_nxt;
  seg_t          cur_r, cur_nxt;
  seg_t          prev_r, prev_nxt;
  logic          has_prev_r, has_prev_nxt;
  logic          has_next_r, has_next_nxt;
  addr_t         blk_r, blk_nxt;
  size_t         size_r, size_nxt;
  alu_word_t     tmp_r, tmp_nxt;
  logic          jp_r, jp_nxt;
  status_t       res_status_r, res_status_nxt;
  addr_t         res_user_r, res_user_nxt;
  status_t       out_status_r, out_status_nxt;
  addr_t         out_user_r, out_user_nxt;

  // shared unit
  alu_req_t alu_req;
  alu_res_t alu_res;

  // segment table ram
  logic          seg_we;
  logic [IW-1:0] seg_waddr;
  seg_t          seg_wdata;
  logic          seg_re;
  logic [IW-1:0] seg_raddr;
  seg_t          seg_rd;

  // block size store
  logic  sz_we;
  addr_t sz_waddr;
  size_t sz_wdata;
  logic  sz_re;
  addr_t sz_raddr;
  size_t sz_rd;

  // index neighbours
  logic [CW-1:0] src_dec, src_inc, hit_dec, hit_inc, k_dec, k_inc;
  size_t         size_sel;

  assign src_dec = src_r - 1'b1;
  assign src_inc = src_r + 1'b1;
  assign hit_dec = hit_r - 1'b1;
  assign hit_inc = hit_r + 1'b1;
  assign k_dec   = k_r - 1'b1;
  assign k_inc   = k_r + 1'b1;

  ffha_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  ffha_ram #(
    .WIDTH (SEG_W),
    .DEPTH (MAX_SEGMENTS)
  ) u_seg_ram (
    .clk     (clk),
    .wr_en   (seg_we),
    .wr_addr (seg_waddr),
    .wr_data (seg_wdata),
    .rd_en   (seg_re),
    .rd_addr (seg_raddr),
    .rd_data (seg_rd)
  );

  ffha_ram #(
    .WIDTH (SIZE_W),
    .DEPTH (HEAP_BYTES)
  ) u_size_ram (
    .clk     (clk),
    .wr_en   (sz_we),
    .wr_addr (sz_waddr),
    .wr_data (sz_wdata),
    .rd_en   (sz_re),
    .rd_addr (sz_raddr),
    .rd_data (sz_rd)
  );

  // handshake outputs
  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_user_address = out_user_r;
  assign cfg_ready        = 1'b1;

  // clipped block size on a free
  assign size_sel = alu_res.gt ? tmp_r[SIZE_W-1:0] : sz_rd;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r & out_stall;
    kind_nxt       = kind_r;
    opnd_nxt       = opnd_r;
    need_nxt       = need_r;
    k_nxt          = k_r;
    src_nxt        = src_r;
    pend_nxt       = pend_r;
    hit_nxt        = hit_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    has_prev_nxt   = has_prev_r;
    has_next_nxt   = has_next_r;
    blk_nxt        = blk_r;
    size_nxt       = size_r;
    tmp_nxt        = tmp_r;
    jp_nxt         = jp_r;
    res_status_nxt = res_status_r;
    res_user_nxt   = res_user_r;
    out_status_nxt = out_status_r;
    out_user_nxt   = out_user_r;

    alu_req   = '0;
    seg_we    = 1'b0;
    seg_waddr = '0;
    seg_wdata = '0;
    seg_re    = 1'b0;
    seg_raddr = '0;
    sz_we     = 1'b0;
    sz_waddr  = '0;
    sz_wdata  = '0;
    sz_re     = 1'b0;
    sz_raddr  = '0;

    unique case (state_r)
      // write the whole-heap segment into entry 0
      S_INIT: begin
        seg_we    = 1'b1;
        seg_wdata = '{start: '0, length: SIZE_W'(HEAP_BYTES)};
        state_nxt = S_IDLE;
      end

      // take a transaction
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt       = in_kind;
          opnd_nxt       = (in_kind == KIND_FREE) ? in_free_address : in_request_size;
          res_status_nxt = ST_OK;
          res_user_nxt   = '0;
          if (in_kind == KIND_FREE) begin
            state_nxt = S_F_RANGE;
          end else if (in_request_size == '0) begin
            res_status_nxt = ST_NOFIT;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_A_NEED;
          end
        end
      end

      // need = request plus header
      S_A_NEED: begin
        alu_req   = '{a: ALU_W'(opnd_r), b: HDR_W};
        need_nxt  = alu_res.sum[SIZE_W-1:0];
        k_nxt     = '0;
        pend_nxt  = 1'b0;
        state_nxt = S_A_SCAN;
      end

      // first segment long enough, one entry per cycle
      S_A_SCAN: begin
        alu_req = '{a: ALU_W'(seg_rd.length), b: ALU_W'(need_r)};
        if (pend_r && alu_res.ge) begin
          cur_nxt   = seg_rd;
          hit_nxt   = src_r;
          state_nxt = S_A_THR;
        end else if (k_r < count_r) begin
          seg_re    = 1'b1;
          seg_raddr = k_r[IW-1:0];
          src_nxt   = k_r;
          k_nxt     = k_inc;
          pend_nxt  = 1'b1;
        end else begin
          res_status_nxt = ST_NOFIT;
          state_nxt      = S_DONE;
        end
      end

      // split threshold
      S_A_THR: begin
        alu_req   = '{a: ALU_W'(need_r), b: ALU_W'(msr_r)};
        tmp_nxt   = alu_res.sum;
        state_nxt = S_A_CMP;
      end

      S_A_CMP: begin
        alu_req   = '{a: ALU_W'(cur_r.length), b: tmp_r};
        state_nxt = alu_res.gt ? S_A_SPLIT : S_A_TAKE;
      end

      // shorten the segment by the block
      S_A_SPLIT: begin
        alu_req        = '{a: ALU_W'(cur_r.length), b: ALU_W'(need_r)};
        cur_nxt.length = alu_res.diff[SIZE_W-1:0];
        state_nxt      = S_A_BLK;
      end

      // block sits at the top end of the segment
      S_A_BLK: begin
        alu_req   = '{a: ALU_W'(cur_r.start), b: ALU_W'(cur_r.length)};
        blk_nxt   = alu_res.sum[ADDR_W-1:0];
        seg_we    = 1'b1;
        seg_waddr = hit_r[IW-1:0];
        seg_wdata = cur_r;
        sz_we     = 1'b1;
        sz_waddr  = alu_res.sum[ADDR_W-1:0];
        sz_wdata  = need_r;
        state_nxt = S_A_USER;
      end

      // whole segment taken, then removed from the table
      S_A_TAKE: begin
        blk_nxt   = cur_r.start;
        sz_we     = 1'b1;
        sz_waddr  = cur_r.start;
        sz_wdata  = cur_r.length;
        k_nxt     = hit_inc;
        pend_nxt  = 1'b0;
        state_nxt = S_DROP;
      end

      S_A_USER: begin
        alu_req        = '{a: ALU_W'(blk_r), b: HDR_W};
        res_user_nxt   = alu_res.sum[ADDR_W-1:0];
        res_status_nxt = ST_OK;
        state_nxt      = S_DONE;
      end

      // address range and header offset
      S_F_RANGE: begin
        alu_req = '{a: ALU_W'(opnd_r), b: HDR_W};
        if (!alu_res.ge || ({1'b0, opnd_r} >= SIZE_W'(HEAP_BYTES))) begin
          res_status_nxt = ST_RANGE;
          state_nxt      = S_DONE;
        end else begin
          blk_nxt   = alu_res.diff[ADDR_W-1:0];
          state_nxt = S_F_LIM;
        end
      end

      // room left to the heap end, read the stored size
      S_F_LIM: begin
        alu_req   = '{a: HEAP_W, b: ALU_W'(blk_r)};
        tmp_nxt   = alu_res.diff;
        sz_re     = 1'b1;
        sz_raddr  = blk_r;
        state_nxt = S_F_CLIP;
      end

      // clip to heap end, zero size changes nothing
      S_F_CLIP: begin
        alu_req      = '{a: ALU_W'(sz_rd), b: tmp_r};
        size_nxt     = size_sel;
        k_nxt        = '0;
        pend_nxt     = 1'b0;
        has_prev_nxt = 1'b0;
        state_nxt    = (size_sel == '0) ? S_DONE : S_F_SCAN;
      end

      // first segment starting past the block, keep its predecessor
      S_F_SCAN: begin
        alu_req = '{a: ALU_W'(seg_rd.start), b: ALU_W'(blk_r)};
        if (pend_r && alu_res.gt) begin
          cur_nxt      = seg_rd;
          hit_nxt      = src_r;
          has_next_nxt = 1'b1;
          state_nxt    = S_F_PEND;
        end else begin
          if (pend_r) begin
            prev_nxt     = seg_rd;
            has_prev_nxt = 1'b1;
          end
          if (k_r < count_r) begin
            seg_re    = 1'b1;
            seg_raddr = k_r[IW-1:0];
            src_nxt   = k_r;
            k_nxt     = k_inc;
            pend_nxt  = 1'b1;
          end else begin
            hit_nxt      = count_r;
            has_next_nxt = 1'b0;
            state_nxt    = S_F_PEND;
          end
        end
      end

      // end of the previous segment
      S_F_PEND: begin
        alu_req   = '{a: ALU_W'(prev_r.start), b: ALU_W'(prev_r.length)};
        tmp_nxt   = alu_res.sum;
        state_nxt = S_F_JP;
      end

      S_F_JP: begin
        alu_req   = '{a: tmp_r, b: ALU_W'(blk_r)};
        jp_nxt    = has_prev_r & alu_res.eq;
        state_nxt = S_F_END;
      end

      // end of the freed block
      S_F_END: begin
        alu_req   = '{a: ALU_W'(blk_r), b: ALU_W'(size_r)};
        tmp_nxt   = alu_res.sum;
        state_nxt = S_F_JN;
      end

      // pick the merge case, or report a full table, or go on to a plain insert
      S_F_JN: begin
        alu_req = '{a: tmp_r, b: ALU_W'(cur_r.start)};
        if (jp_r && has_next_r && alu_res.eq) begin
          state_nxt = S_F_MERGE1;
        end else if (jp_r) begin
          state_nxt = S_F_PREV;
        end else if (has_next_r && alu_res.eq) begin
          state_nxt = S_F_NEXT;
        end else if (count_r >= CW'(MAX_SEGMENTS)) begin
          res_status_nxt = ST_FULL;
          state_nxt      = S_DONE;
        end else begin
          k_nxt     = count_r;
          pend_nxt  = 1'b0;
          state_nxt = S_F_SHUP;
        end
      end

      // merge on both sides: previous absorbs block and next
      S_F_MERGE1: begin
        alu_req   = '{a: ALU_W'(prev_r.length), b: ALU_W'(size_r)};
        tmp_nxt   = alu_res.sum;
        state_nxt = S_F_MERGE2;
      end

      S_F_MERGE2: begin
        alu_req   = '{a: tmp_r, b: ALU_W'(cur_r.length)};
        seg_we    = 1'b1;
        seg_waddr = hit_dec[IW-1:0];
        seg_wdata = '{start: prev_r.start, length: alu_res.sum[SIZE_W-1:0]};
        k_nxt     = hit_inc;
        pend_nxt  = 1'b0;
        state_nxt = S_DROP;
      end

      // grow the previous segment
      S_F_PREV: begin
        alu_req   = '{a: ALU_W'(prev_r.length), b: ALU_W'(size_r)};
        seg_we    = 1'b1;
        seg_waddr = hit_dec[IW-1:0];
        seg_wdata = '{start: prev_r.start, length: alu_res.sum[SIZE_W-1:0]};
        state_nxt = S_DONE;
      end

      // grow the next segment downward
      S_F_NEXT: begin
        alu_req   = '{a: ALU_W'(cur_r.length), b: ALU_W'(size_r)};
        seg_we    = 1'b1;
        seg_waddr = hit_r[IW-1:0];
        seg_wdata = '{start: blk_r, length: alu_res.sum[SIZE_W-1:0]};
        state_nxt = S_DONE;
      end

      // open a hole at the insert index, top entry first
      S_F_SHUP: begin
        if (pend_r) begin
          seg_we    = 1'b1;
          seg_waddr = src_inc[IW-1:0];
          seg_wdata = seg_rd;
        end
        if (k_r > hit_r) begin
          seg_re    = 1'b1;
          seg_raddr = k_dec[IW-1:0];
          src_nxt   = k_dec;
          k_nxt     = k_dec;
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_F_INS;
        end
      end

      S_F_INS: begin
        seg_we    = 1'b1;
        seg_waddr = hit_r[IW-1:0];
        seg_wdata = '{start: blk_r, length: size_r};
        count_nxt = count_r + 1'b1;
        state_nxt = S_DONE;
      end

      // close the gap left by a removed entry
      S_DROP: begin
        if (pend_r) begin
          seg_we    = 1'b1;
          seg_waddr = src_dec[IW-1:0];
          seg_wdata = seg_rd;
        end
        if (k_r < count_r) begin
          seg_re    = 1'b1;
          seg_raddr = k_r[IW-1:0];
          src_nxt   = k_r;
          k_nxt     = k_inc;
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          count_nxt = count_r - 1'b1;
          state_nxt = (kind_r == KIND_ALLOC) ? S_A_USER : S_DONE;
        end
      end

      // hand the result to the output register
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_user_nxt   = res_user_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      count_r     <= CW'(1);
      out_valid_r <= 1'b0;
      msr_r       <= MSR_RESET;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      if (cfg_valid && cfg_ready) begin
        msr_r <= cfg_min_split_remainder;
      end
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    opnd_r       <= opnd_nxt;
    need_r       <= need_nxt;
    k_r          <= k_nxt;
    src_r        <= src_nxt;
    hit_r        <= hit_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    has_prev_r   <= has_prev_nxt;
    has_next_r   <= has_next_nxt;
    blk_r        <= blk_nxt;
    size_r       <= size_nxt;
    tmp_r        <= tmp_nxt;
    jp_r         <= jp_nxt;
    res_status_r <= res_status_nxt;
    res_user_r   <= res_user_nxt;
    out_status_r <= out_status_nxt;
    out_user_r   <= out_user_nxt;
  end

  // checks
  logic chk_done_full, chk_scanning, chk_accept, chk_busy;

  assign chk_done_full = (state_r == S_DONE) && (res_status_r == ST_FULL);
  assign chk_scanning  = (state_r == S_A_SCAN) || (state_r == S_F_SCAN);
  assign chk_accept    = in_valid && !in_stall;
  assign chk_busy      = (state_r != S_IDLE) && (state_r != S_INIT);

  `FFHA_ASSERT_ALWAYS(a_count_bound, count_r <= CW'(MAX_SEGMENTS), "count past table depth")
  `FFHA_ASSERT_IMPL(a_full_status, chk_done_full, count_r == CW'(MAX_SEGMENTS), "full with room")
  `FFHA_ASSERT_IMPL(a_scan_ptr, chk_scanning, k_r <= count_r, "scan pointer past count")
  `FFHA_ASSERT_NEXT(a_accept_busy, chk_accept, chk_busy, "accepted transaction left block idle")

endmodule

>>> design/ffha_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/ffha_alu.sv
// shared add, subtract and compare unit of the heap allocator
// depends on ffha_pkg
module ffha_alu (
  input  ffha_pkg::alu_req_t req,
  output ffha_pkg::alu_res_t res
);
  import ffha_pkg::*;

  // one adder, one subtractor, one magnitude compare and one equality compare
  always_comb begin
    res.sum  = req.a + req.b;
    res.diff = req.a - req.b;
    res.ge   = (req.a >= req.b);
    res.eq   = (req.a == req.b);
    res.gt   = res.ge & ~res.eq;
  end

endmodule

>>> tb/tb.sv
// self-checking testbench for first_fit_heap_allocator_core
// depends on ffha_pkg and the allocator rtl; models the free segment table internally
`timescale 1ns / 1ps

module tb;
  import ffha_pkg::*;

  localparam int HDR_BYTES = 4;
  localparam int SEG_SLOTS = 128;

  typedef struct packed {
    status_t status;
    addr_t   user;
  } outcome_t;

  typedef struct packed {
    logic     kind;
    addr_t    req;
    addr_t    addr;
    logic     typed;
    outcome_t want;
  } stim_row_t;

  // clock, reset and block ports
  logic    clk;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  logic    in_kind = KIND_ALLOC;
  addr_t   in_request_size = '0;
  addr_t   in_free_address = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  status_t out_status;
  addr_t   out_user_address;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  addr_t   cfg_min_split_remainder = '0;

  // allocator image: free segment table, size store and split threshold
  int unsigned free_start [SEG_SLOTS];
  int unsigned free_len [SEG_SLOTS];
  int unsigned free_count;
  int unsigned blk_size [HEAP_BYTES];
  bit          size_written [HEAP_BYTES];
  int unsigned split_margin;

  outcome_t    pending_results [$];
  addr_t       live_users [$];
  int unsigned mismatch_count = 0;
  bit          gaps_on = 1'b1;
  int unsigned stall_left = 0;

  // directed opening sequence from a fresh heap with the reset threshold
  stim_row_t opening_rows [19] = '{
    '{KIND_ALLOC, 10'd0,    10'd5,    1'b1, '{ST_NOFIT, 10'd0}},
    '{KIND_ALLOC, 10'd1023, 10'd0,    1'b1, '{ST_NOFIT, 10'd0}},
    '{KIND_FREE,  10'd1023, 10'd0,    1'b1, '{ST_RANGE, 10'd0}},
    '{KIND_FREE,  10'd0,    10'd3,    1'b1, '{ST_RANGE, 10'd0}},
    '{KIND_ALLOC, 10'd1020, 10'd1023, 1'b1, '{ST_OK,    10'd4}},
    '{KIND_ALLOC, 10'd1,    10'd0,    1'b1, '{ST_NOFIT, 10'd0}},
    '{KIND_FREE,  10'd512,  10'd4,    1'b1, '{ST_OK,    10'd0}},
    '{KIND_ALLOC, 10'd100,  10'd0,    1'b0, '{ST_OK,    10'd0}},
    '{KIND_ALLOC, 10'd200,  10'd0,    1'b0, '{ST_OK,    10'd0}},
    '{KIND_ALLOC, 10'd1,    10'd0,    1'b0, '{ST_OK,    10'd0}},
    '{KIND_FREE,  10'd0,    10'd720,  1'b0, '{ST_OK,    10'd0}},
    '{KIND_FREE,  10'd0,    10'd924,  1'b0, '{ST_OK,    10'd0}},
    '{KIND_FREE,  10'd0,    10'd715,  1'b0, '{ST_OK,    10'd0}},
    '{KIND_ALLOC, 10'd1,    10'd0,    1'b0, '{ST_OK,    10'd0}},
    '{KIND_FREE,  10'd0,    10'd1023, 1'b0, '{ST_OK,    10'd0}},
    '{KIND_FREE,  10'd0,    10'd1023, 1'b0, '{ST_OK,    10'd0}},
    '{KIND_ALLOC, 10'd1020, 10'd0,    1'b0, '{ST_OK,    10'd0}},
    '{KIND_ALLOC, 10'd1,    10'd0,    1'b0, '{ST_OK,    10'd0}},
    '{KIND_FREE,  10'd0,    10'd4,    1'b0, '{ST_OK,    10'd0}}
  };

  first_fit_heap_allocator_core #(
    .MAX_SEGMENTS(SEG_SLOTS),
    .HEADER_BYTES(HDR_BYTES)
  ) i_dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_kind                 (in_kind),
    .in_request_size         (in_request_size),
    .in_free_address         (in_free_address),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_status              (out_status),
    .out_user_address        (out_user_address),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_min_split_remainder (cfg_min_split_remainder)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // remove one table entry, closing the gap
  function automatic void drop_free_entry(int unsigned idx);
    for (int unsigned k = idx; k + 1 < free_count; k++) begin
      free_start[k] = free_start[k + 1];
      free_len[k]   = free_len[k + 1];
    end
    free_count--;
  endfunction

  // first fit, carving from the top of the segment when enough is left over
  function automatic outcome_t predict_alloc(addr_t req);
    outcome_t    res;
    int unsigned need;
    int unsigned idx;
    int unsigned blk;
    int unsigned bytes;
    res.status = ST_NOFIT;
    res.user   = '0;
    need       = req + HDR_BYTES;
    if (req == 0) return res;
    idx = 0;
    while (idx < free_count && free_len[idx] < need) idx++;
    if (idx >= free_count) return res;
    if (free_len[idx] > need + split_margin) begin
      blk = free_start[idx] + free_len[idx] - need;
      free_len[idx] -= need;
      bytes = need;
    end else begin
      blk   = free_start[idx];
      bytes = free_len[idx];
      drop_free_entry(idx);
    end
    if (blk < HEAP_BYTES) begin
      blk_size[blk]     = bytes;
      size_written[blk] = 1'b1;
    end
    res.status = ST_OK;
    res.user   = addr_t'(blk + HDR_BYTES);
    return res;
  endfunction

  // return a block to the table, merging with free neighbors
  function automatic outcome_t predict_release(addr_t addr);
    outcome_t    res;
    int unsigned blk;
    int unsigned bytes;
    int unsigned idx;
    bit          join_prev;
    bit          join_next;
    res.status = ST_OK;
    res.user   = '0;
    if (addr < HDR_BYTES) begin
      res.status = ST_RANGE;
      return res;
    end
    blk   = addr - HDR_BYTES;
    bytes = blk_size[blk];
    if (bytes > HEAP_BYTES - blk) bytes = HEAP_BYTES - blk;
    if (bytes == 0) return res;
    idx = 0;
    while (idx < free_count && free_start[idx] <= blk) idx++;
    join_prev = (idx > 0) && (free_start[idx - 1] + free_len[idx - 1] == blk);
    join_next = (idx < free_count) && (blk + bytes == free_start[idx]);
    if (join_prev && join_next) begin
      free_len[idx - 1] += bytes + free_len[idx];
      drop_free_entry(idx);
    end else if (join_prev) begin
      free_len[idx - 1] += bytes;
    end else if (join_next) begin
      free_start[idx] = blk;
      free_len[idx]  += bytes;
    end else if (free_count >= SEG_SLOTS) begin
      res.status = ST_FULL;
    end else begin
      for (int unsigned k = free_count; k > idx; k--) begin
        free_start[k] = free_start[k - 1];
        free_len[k]   = free_len[k - 1];
      end
      free_start[idx] = blk;
      free_len[idx]   = bytes;
      free_count++;
    end
    return res;
  endfunction

  // present one transaction, wait for its acceptance, then record what it must return
  task automatic issue_request(input logic kind, input addr_t req, input addr_t addr,
                               input logic typed, input outcome_t typed_want);
    outcome_t predicted;
    if (gaps_on && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_request_size <= req;
    in_free_address <= addr;
    do @(posedge clk); while (in_stall);
    if (kind == KIND_ALLOC) predicted = predict_alloc(req);
    else predicted = predict_release(addr);
    if (kind == KIND_ALLOC && predicted.status == ST_OK) live_users.push_back(predicted.user);
    pending_results.push_back(typed ? typed_want : predicted);
  endtask

  function automatic addr_t pick_request();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2) return '0;
    if (r < 72) return addr_t'($urandom_range(1, 48));
    if (r < 92) return addr_t'($urandom_range(49, 300));
    return addr_t'($urandom_range(301, 1023));
  endfunction

  // some header offset whose size entry holds a value, or -1
  function automatic int pick_written_block();
    int unsigned base;
    int unsigned span;
    span = HEAP_BYTES - HDR_BYTES;
    base = $urandom_range(0, span - 1);
    for (int unsigned n = 0; n < span; n++) begin
      int unsigned b;
      b = (base + n) % span;
      if (size_written[b]) return b;
    end
    return -1;
  endfunction

  // mostly alloc / free of live blocks, some double frees and out-of-range addresses
  function automatic void next_random_item(output logic kind, output addr_t req,
                                           output addr_t addr);
    int unsigned r;
    int          pick;
    int          slot;
    kind = KIND_ALLOC;
    req  = pick_request();
    addr = addr_t'($urandom_range(0, 1023));
    r    = $urandom_range(0, 99);
    if (r >= 45 && r < 85 && live_users.size() > 0) begin
      slot = $urandom_range(0, live_users.size() - 1);
      addr = live_users[slot];
      live_users.delete(slot);
      kind = KIND_FREE;
    end else if (r >= 85 && r < 93) begin
      pick = pick_written_block();
      if (pick >= 0) begin
        kind = KIND_FREE;
        addr = addr_t'(pick + HDR_BYTES);
      end
    end else if (r >= 93) begin
      kind = KIND_FREE;
      addr = addr_t'($urandom_range(0, HDR_BYTES - 1));
    end
    // never free an offset whose size was never stored
    if (kind == KIND_FREE && addr >= HDR_BYTES && !size_written[addr - HDR_BYTES])
      kind = KIND_ALLOC;
  endfunction

  task automatic run_random(input int count, input bit flood, input bit allow_gaps);
    logic     kind;
    addr_t    req;
    addr_t    addr;
    int       pick;
    outcome_t none;
    none = '{ST_OK, 10'd0};
    gaps_on = allow_gaps;
    // repeated free of one block stacks duplicate segments until the table is full
    if (flood) begin
      pick = pick_written_block();
      if (pick >= 0)
        repeat (135)
          issue_request(KIND_FREE, addr_t'($urandom), addr_t'(pick + HDR_BYTES), 1'b0, none);
    end
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) gaps_on = allow_gaps && ($urandom_range(0, 2) != 0);
      next_random_item(kind, req, addr);
      issue_request(kind, req, addr, 1'b0, none);
    end
    in_valid <= 1'b0;
  endtask

  // register write once all results are back
  task automatic write_split_margin(input addr_t value);
    wait (pending_results.size() == 0);
    @(posedge clk);
    cfg_valid               <= 1'b1;
    cfg_min_split_remainder <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    split_margin = value;
  endtask

  // result side back-pressure in bursts
  always @(posedge clk) begin
    if (!rst_n || !gaps_on) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 8) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 17);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: status %0d user %0d",
                                  out_status, out_user_address));
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
        if (out_user_address !== want.user)
          report_mismatch($sformatf("user_address %0d, expected %0d",
                                    out_user_address, want.user));
      end
    end
  end

  // stimulus
  initial begin
    free_start[0] = 0;
    free_len[0]   = HEAP_BYTES;
    free_count    = 1;
    split_margin  = MSR_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset threshold: directed rows, then random traffic
    foreach (opening_rows[n])
      issue_request(opening_rows[n].kind, opening_rows[n].req, opening_rows[n].addr,
                    opening_rows[n].typed, opening_rows[n].want);
    run_random(70, 1'b0, 1'b1);

    // threshold extremes, a random one with a full-table flood, then a run without idling
    write_split_margin(10'd0);
    run_random(80, 1'b0, 1'b1);
    write_split_margin(10'd1023);
    run_random(70, 1'b0, 1'b1);
    write_split_margin(addr_t'($urandom_range(0, 1023)));
    run_random(50, 1'b1, 1'b1);
    write_split_margin(10'd5);
    run_random(90, 1'b0, 1'b0);

    wait (pending_results.size() == 0);
    repeat (300) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> first_fit_heap_allocator_core.f
+incdir+design
design/ffha_pkg.sv
design/ffha_ram.sv
design/ffha_alu.sv
design/first_fit_heap_allocator_core.sv
tb/tb.sv
